>>> hdl/sckb_pkg.sv
package sckb_pkg;

  // frame buffer geometry
  localparam int LINE_STRIDE = 512;
  localparam int FRAME_WORDS = 139264;
  localparam int PIXEL_STEP  = 1;
  localparam int MAX_SCALE   = 8;

  // visible area corner
  localparam int VIS_LAST_X = 479;
  localparam int VIS_LAST_Y = 271;
  localparam int VIS_SPAN   = VIS_LAST_X * PIXEL_STEP + VIS_LAST_Y * LINE_STRIDE;

  // field widths
  localparam int COORD_W = 9;
  localparam int PIX_W   = 16;
  localparam int MAG_W   = 4;
  localparam int WADDR_W = 19;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 3;

  // scaled source offset: 9-bit position times 4-bit magnification
  localparam int POS_W  = COORD_W + MAG_W;
  // internal linear address, wide enough for unclipped block corners
  localparam int ADDR_W = 23;

  localparam logic [PIX_W-1:0] KEY_COLOR = 16'h7c1f;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_BLIT_WIDTH  = 3'd2,
    REG_BLIT_HEIGHT = 3'd3,
    REG_SCALE       = 3'd4,
    REG_KEY_ENABLE  = 3'd5,
    REG_DRAW_FRAME  = 3'd6
  } reg_idx_t;

endpackage

>>> hdl/scaled_color_key_blitter.sv
// path: an item passes stages 1 to 3, the write generator, the output register
// throughput: one item per cycle at scale 1 or with keying; any other item that
//   is drawn holds the write generator while it walks its mag by mag block, mag
//   being the scale saturated at eight; items dropped in stage 1 do not hold it
// reset: rst restores the configuration registers and empties the pipeline
// the receiver cannot stall: each write is shown for one cycle with strobe
module scaled_color_key_blitter (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [sckb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sckb_pkg::CFG_W-1:0]    cfg_data,
  // item input
  input  logic                          start,
  output logic                          busy,
  input  logic [sckb_pkg::COORD_W-1:0]  src_col,
  input  logic [sckb_pkg::COORD_W-1:0]  src_row,
  input  logic [sckb_pkg::PIX_W-1:0]    pixel,
  // write output
  output logic                          strobe,
  output logic [sckb_pkg::WADDR_W-1:0]  write_addr,
  output logic [sckb_pkg::PIX_W-1:0]    write_data,
  output logic                          last_write
);

  localparam int AW = sckb_pkg::ADDR_W;
  localparam int MW = sckb_pkg::MAG_W;
  localparam int PW = sckb_pkg::POS_W;

  // configuration registers
  logic [sckb_pkg::COORD_W-1:0] dest_x, dest_y, blit_width, blit_height;
  logic [MW-1:0]                scale;
  logic                         key_enable, draw_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x      <= '0;
      dest_y      <= '0;
      blit_width  <= sckb_pkg::COORD_W'(1);
      blit_height <= sckb_pkg::COORD_W'(1);
      scale       <= MW'(1);
      key_enable  <= 1'b0;
      draw_frame  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sckb_pkg::REG_DEST_X:      dest_x      <= cfg_data;
        sckb_pkg::REG_DEST_Y:      dest_y      <= cfg_data;
        sckb_pkg::REG_BLIT_WIDTH:  blit_width  <= cfg_data;
        sckb_pkg::REG_BLIT_HEIGHT: blit_height <= cfg_data;
        sckb_pkg::REG_SCALE:       scale       <= cfg_data[MW-1:0];
        sckb_pkg::REG_KEY_ENABLE:  key_enable  <= cfg_data[0];
        sckb_pkg::REG_DRAW_FRAME:  draw_frame  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // visible address window of the selected frame
  logic [AW-1:0] win_lo, win_hi;
  assign win_lo = draw_frame ? AW'(sckb_pkg::FRAME_WORDS) : '0;
  assign win_hi = win_lo + AW'(sckb_pkg::VIS_SPAN);

  // pipeline handshake
  logic s1_valid, s2_valid, s3_valid, g_active;
  logic g_final, adv, s2_move, s1_move;

  assign adv     = !g_active || g_final;
  assign s2_move = !s3_valid || adv;
  assign s1_move = !s2_valid || s2_move;
  assign busy    = s1_valid && !s1_move;

  // stage 1: captured item
  logic [sckb_pkg::COORD_W-1:0] s1_col, s1_row;
  logic [sckb_pkg::PIX_W-1:0]   s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!busy) begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      s1_col <= src_col;
      s1_row <= src_row;
      s1_pix <= pixel;
    end
  end

  // magnification; rejects items outside the blit, keyed out or at scale zero
  logic [MW-1:0] s1_mag;
  logic          s1_keep;

  always_comb begin
    if (key_enable) begin
      s1_mag = MW'(1);
    end else if (scale > MW'(sckb_pkg::MAX_SCALE)) begin
      s1_mag = MW'(sckb_pkg::MAX_SCALE);
    end else begin
      s1_mag = scale;
    end
    s1_keep = (s1_col < blit_width) && (s1_row < blit_height) &&
              !(key_enable && (s1_pix == sckb_pkg::KEY_COLOR)) &&
              (s1_mag != '0);
  end

  // stage 2: scaled source offsets
  logic [PW-1:0]              s2_colm, s2_rowm;
  logic [MW-1:0]              s2_mag;
  logic [sckb_pkg::PIX_W-1:0] s2_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= s1_valid && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_colm <= PW'(s1_col) * PW'(s1_mag);
      s2_rowm <= PW'(s1_row) * PW'(s1_mag);
      s2_mag  <= s1_mag;
      s2_pix  <= s1_pix;
    end
  end

  // stage 3: linear address of the block corner and the row jump
  logic [AW-1:0]              s3_addr, s3_jump;
  logic [MW-1:0]              s3_mag;
  logic [sckb_pkg::PIX_W-1:0] s3_pix;
  logic [AW-1:0]              x0, y0;

  assign x0 = AW'(dest_x) + AW'(s2_colm);
  assign y0 = AW'(dest_y) + AW'(s2_rowm);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_move) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_addr <= win_lo + x0 * AW'(sckb_pkg::PIXEL_STEP) + y0 * AW'(sckb_pkg::LINE_STRIDE);
      s3_jump <= AW'(sckb_pkg::LINE_STRIDE) -
                 AW'(s2_mag - MW'(1)) * AW'(sckb_pkg::PIXEL_STEP);
      s3_mag  <= s2_mag;
      s3_pix  <= s2_pix;
    end
  end

  // write generator: walks the block in row-major order
  logic [AW-1:0]              g_addr, g_jump, g_addr_nx;
  logic [MW-1:0]              g_mx, g_my, g_mag;
  logic [sckb_pkg::PIX_W-1:0] g_pix;
  logic                       g_row_end, g_in, g_nx_in;

  assign g_row_end = (g_mx == g_mag - MW'(1));
  assign g_final   = g_row_end && (g_my == g_mag - MW'(1));
  assign g_addr_nx = g_row_end ? g_addr + g_jump : g_addr + AW'(sckb_pkg::PIXEL_STEP);
  assign g_in      = (g_addr >= win_lo) && (g_addr <= win_hi);
  assign g_nx_in   = (g_addr_nx >= win_lo) && (g_addr_nx <= win_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_active <= 1'b0;
    end else if (adv) begin
      g_active <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_addr <= s3_addr;
      g_jump <= s3_jump;
      g_mag  <= s3_mag;
      g_pix  <= s3_pix;
      g_mx   <= '0;
      g_my   <= '0;
    end else begin
      g_addr <= g_addr_nx;
      if (g_row_end) begin
        g_mx <= '0;
        g_my <= g_my + MW'(1);
      end else begin
        g_mx <= g_mx + MW'(1);
      end
    end
  end

  // output register; addresses rise within a block, so the visible writes
  // form one run; the last one ends the block or is the last inside the window
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= g_active && g_in;
    end
  end

  always_ff @(posedge clk) begin
    write_addr <= g_addr[sckb_pkg::WADDR_W-1:0];
    write_data <= g_pix;
    last_write <= g_final || !g_nx_in;
  end

endmodule

>>> hdl/sckb_checker.sv
module sckb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          busy,
  input logic                          strobe,
  input logic [sckb_pkg::WADDR_W-1:0]  write_addr,
  input logic [sckb_pkg::PIX_W-1:0]    write_data,
  input logic                          last_write
);

  // pipeline empties on reset
  assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("write or busy right after reset");

  // visible writes of one item come in an unbroken run
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |=> strobe)
    else $error("gap inside the writes of one item");

  // all writes of one item carry the same pixel
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |=> write_data == $past(write_data))
    else $error("pixel changed within one item");

  // addresses rise within one item
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |=> write_addr > $past(write_addr))
    else $error("write address not rising within one item");

  // every write lands inside the two frame buffers
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> 20'(write_addr) < 20'(2 * sckb_pkg::FRAME_WORDS))
    else $error("write address beyond both frames");

endmodule

bind scaled_color_key_blitter sckb_checker u_sckb_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .strobe     (strobe),
  .write_addr (write_addr),
  .write_data (write_data),
  .last_write (last_write)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  // up to four drawn items, each with a block to walk, may still be in flight after
  // the last expected write
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_PIXELS  = 38;

  typedef struct packed {
    logic [sckb_pkg::COORD_W-1:0] dx;
    logic [sckb_pkg::COORD_W-1:0] dy;
    logic [sckb_pkg::COORD_W-1:0] bw;
    logic [sckb_pkg::COORD_W-1:0] bh;
    logic [sckb_pkg::MAG_W-1:0]   sc;
    logic                         ke;
    logic                         df;
  } blit_cfg_t;

  typedef struct packed {
    logic [sckb_pkg::WADDR_W-1:0] addr;
    logic [sckb_pkg::PIX_W-1:0]   data;
    logic                         last;
  } pix_write_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [sckb_pkg::IDX_W-1:0]   cfg_index = sckb_pkg::REG_DEST_X;
  logic [sckb_pkg::CFG_W-1:0]   cfg_data = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [sckb_pkg::COORD_W-1:0] src_col = '0;
  logic [sckb_pkg::COORD_W-1:0] src_row = '0;
  logic [sckb_pkg::PIX_W-1:0]   pixel = '0;
  logic                         strobe;
  logic [sckb_pkg::WADDR_W-1:0] write_addr;
  logic [sckb_pkg::PIX_W-1:0]   write_data;
  logic                         last_write;

  // register copy used by the write predictor
  blit_cfg_t  blit_regs;
  pix_write_t pending_writes[$];
  int         sender_idle_pct = 0;
  int         mismatches = 0;
  int         pixels_sent = 0;
  int         writes_seen = 0;
  int         settings_loaded = 0;
  int         cycle_count = 0;

  scaled_color_key_blitter DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start      (start),
    .busy       (busy),
    .src_col    (src_col),
    .src_row    (src_row),
    .pixel      (pixel),
    .strobe     (strobe),
    .write_addr (write_addr),
    .write_data (write_data),
    .last_write (last_write)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic blit_cfg_t make_cfg(int dx, int dy, int bw, int bh, int sc, int ke, int df);
    blit_cfg_t c;
    c.dx = dx[sckb_pkg::COORD_W-1:0];
    c.dy = dy[sckb_pkg::COORD_W-1:0];
    c.bw = bw[sckb_pkg::COORD_W-1:0];
    c.bh = bh[sckb_pkg::COORD_W-1:0];
    c.sc = sc[sckb_pkg::MAG_W-1:0];
    c.ke = ke[0];
    c.df = df[0];
    return c;
  endfunction

  // expected writes of one pixel: replicated block, each write clipped alone
  function automatic void predict_writes(logic [sckb_pkg::COORD_W-1:0] col,
                                         logic [sckb_pkg::COORD_W-1:0] row,
                                         logic [sckb_pkg::PIX_W-1:0] pix);
    pix_write_t blk[$];
    pix_write_t w;
    int mag;
    int base;
    int x0;
    int y0;
    int a;
    if (col >= blit_regs.bw || row >= blit_regs.bh) return;
    if (blit_regs.ke) begin
      if (pix == sckb_pkg::KEY_COLOR) return;
      mag = 1;
    end else begin
      mag = int'(blit_regs.sc);
      if (mag > sckb_pkg::MAX_SCALE) mag = sckb_pkg::MAX_SCALE;
    end
    if (mag == 0) return;
    base = blit_regs.df ? sckb_pkg::FRAME_WORDS : 0;
    x0 = int'(blit_regs.dx) + int'(col) * mag;
    y0 = int'(blit_regs.dy) + int'(row) * mag;
    for (int my = 0; my < mag; my++) begin
      for (int mx = 0; mx < mag; mx++) begin
        a = base + (x0 + mx) * sckb_pkg::PIXEL_STEP + (y0 + my) * sckb_pkg::LINE_STRIDE;
        if (a < base || a > base + sckb_pkg::VIS_SPAN) continue;
        w.addr = a[sckb_pkg::WADDR_W-1:0];
        w.data = pix;
        w.last = 1'b0;
        blk.push_back(w);
      end
    end
    if (blk.size() > 0) blk[blk.size()-1].last = 1'b1;
    foreach (blk[i]) pending_writes.push_back(blk[i]);
  endfunction

  // one register write, enable left high for a following write
  task automatic put_reg(sckb_pkg::reg_idx_t idx, logic [sckb_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_blit_regs(blit_cfg_t c);
    put_reg(sckb_pkg::REG_DEST_X, c.dx);
    put_reg(sckb_pkg::REG_DEST_Y, c.dy);
    put_reg(sckb_pkg::REG_BLIT_WIDTH, c.bw);
    put_reg(sckb_pkg::REG_BLIT_HEIGHT, c.bh);
    put_reg(sckb_pkg::REG_SCALE, sckb_pkg::CFG_W'(c.sc));
    put_reg(sckb_pkg::REG_KEY_ENABLE, sckb_pkg::CFG_W'(c.ke));
    put_reg(sckb_pkg::REG_DRAW_FRAME, sckb_pkg::CFG_W'(c.df));
    cfg_we <= 1'b0;
    blit_regs = c;
    settings_loaded++;
  endtask

  // present one pixel until accepted, then maybe idle for a random gap
  task automatic send_pixel(logic [sckb_pkg::COORD_W-1:0] col,
                            logic [sckb_pkg::COORD_W-1:0] row,
                            logic [sckb_pkg::PIX_W-1:0] pix);
    int gap;
    gap = 0;
    start <= 1'b1;
    src_col <= col;
    src_row <= row;
    pixel <= pix;
    do @(posedge clk); while (busy);
    predict_writes(col, row, pix);
    pixels_sent++;
    while (gap < 12 && $urandom_range(99, 0) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all expected writes, then cover items still being clipped away
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_writes.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // compare every strobed write with the oldest expectation
  always @(posedge clk) begin
    pix_write_t exp_w;
    if (!rst && strobe) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: write_addr %0h write_data %0h", write_addr, write_data);
        mismatches++;
      end else begin
        exp_w = pending_writes.pop_front();
        if (write_addr !== exp_w.addr) begin
          $error("write_addr: expected %0h, got %0h", exp_w.addr, write_addr);
          mismatches++;
        end
        if (write_data !== exp_w.data) begin
          $error("write_data: expected %0h, got %0h", exp_w.data, write_data);
          mismatches++;
        end
        if (last_write !== exp_w.last) begin
          $error("last_write: expected %0b, got %0b", exp_w.last, last_write);
          mismatches++;
        end
      end
    end
  end

  // pixels under the reset register values
  task automatic test_reset_values();
    send_pixel(9'd0, 9'd0, 16'h1234);
    send_pixel(9'd1, 9'd0, 16'h4321);
    send_pixel(9'd0, 9'd1, 16'h5a5a);
    wait_idle();
  endtask

  // corners of the source image and of each frame
  task automatic test_field_extremes();
    load_blit_regs(make_cfg(0, 0, 480, 272, 1, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h0000);
    send_pixel(9'd479, 9'd271, 16'hffff);
    send_pixel(9'd480, 9'd5, 16'h1111);
    send_pixel(9'd5, 9'd272, 16'h2222);
    send_pixel(9'd511, 9'd511, 16'h3333);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 272, 1, 0, 1));
    send_pixel(9'd479, 9'd271, 16'ha5a5);
    wait_idle();
  endtask

  // full blocks, saturation above the maximum, and scale zero
  task automatic test_scaling();
    load_blit_regs(make_cfg(0, 0, 480, 272, 8, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h0f0f);
    send_pixel(9'd59, 9'd33, 16'hf0f0);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 272, 15, 0, 1));
    send_pixel(9'd1, 9'd1, 16'h6789);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 272, 3, 0, 0));
    send_pixel(9'd2, 9'd2, 16'h0abc);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 272, 0, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h7777);
    wait_idle();
  endtask

  // partial clipping, linear wrap past the right edge, fully clipped blocks
  task automatic test_clipping();
    load_blit_regs(make_cfg(479, 271, 480, 272, 8, 0, 1));
    send_pixel(9'd0, 9'd0, 16'h1357);
    send_pixel(9'd0, 9'd1, 16'h2468);
    wait_idle();
    load_blit_regs(make_cfg(479, 0, 480, 272, 4, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h8888);
    wait_idle();
    load_blit_regs(make_cfg(511, 511, 511, 511, 1, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h9999);
    wait_idle();
  endtask

  // keyed blit forces scale 1 and drops the key color only when enabled
  task automatic test_color_key();
    load_blit_regs(make_cfg(0, 0, 480, 272, 8, 1, 0));
    send_pixel(9'd3, 9'd3, sckb_pkg::KEY_COLOR);
    send_pixel(9'd3, 9'd3, 16'h7c1e);
    send_pixel(9'd0, 9'd0, 16'hffff);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 272, 2, 0, 1));
    send_pixel(9'd4, 9'd4, sckb_pkg::KEY_COLOR);
    wait_idle();
  endtask

  // zero width or height blocks every pixel
  task automatic test_blocked_sources();
    load_blit_regs(make_cfg(0, 0, 0, 272, 1, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h4444);
    wait_idle();
    load_blit_regs(make_cfg(0, 0, 480, 0, 1, 0, 0));
    send_pixel(9'd0, 9'd0, 16'h5555);
    wait_idle();
  endtask

  function automatic blit_cfg_t rand_cfg();
    blit_cfg_t c;
    int pick;
    c.dx = sckb_pkg::COORD_W'(($urandom_range(99, 0) < 80) ? $urandom_range(479, 0)
                                                            : $urandom_range(511, 0));
    c.dy = sckb_pkg::COORD_W'(($urandom_range(99, 0) < 80) ? $urandom_range(271, 0)
                                                            : $urandom_range(511, 0));
    pick = $urandom_range(99, 0);
    c.bw = sckb_pkg::COORD_W'((pick < 5) ? 0 : (pick < 12) ? $urandom_range(511, 0)
                                                           : $urandom_range(480, 1));
    pick = $urandom_range(99, 0);
    c.bh = sckb_pkg::COORD_W'((pick < 5) ? 0 : (pick < 12) ? $urandom_range(511, 0)
                                                           : $urandom_range(272, 1));
    pick = $urandom_range(99, 0);
    if (pick < 45) c.sc = sckb_pkg::MAG_W'(1);
    else if (pick < 75) c.sc = sckb_pkg::MAG_W'($urandom_range(3, 2));
    else if (pick < 90) c.sc = sckb_pkg::MAG_W'($urandom_range(8, 4));
    else if (pick < 96) c.sc = sckb_pkg::MAG_W'($urandom_range(15, 9));
    else c.sc = '0;
    c.ke = ($urandom_range(99, 0) < 30);
    c.df = 1'($urandom_range(1, 0));
    return c;
  endfunction

  // mostly pixels inside the image near the visible area, some anywhere
  task automatic send_rand_pixel();
    logic [sckb_pkg::COORD_W-1:0] col;
    logic [sckb_pkg::COORD_W-1:0] row;
    logic [sckb_pkg::PIX_W-1:0]   pix;
    int pick;
    int mag;
    int col_top;
    int row_top;
    mag = blit_regs.ke ? 1 : (blit_regs.sc == 0) ? 1 :
          (blit_regs.sc > sckb_pkg::MAX_SCALE) ? sckb_pkg::MAX_SCALE : int'(blit_regs.sc);
    pick = $urandom_range(99, 0);
    if (pick < 85 && blit_regs.bw != 0 && blit_regs.bh != 0) begin
      col_top = int'(blit_regs.bw) - 1;
      row_top = int'(blit_regs.bh) - 1;
      if (pick < 60) begin
        if (col_top > 480 / mag) col_top = 480 / mag;
        if (row_top > 272 / mag) row_top = 272 / mag;
      end
      col = sckb_pkg::COORD_W'($urandom_range(col_top, 0));
      row = sckb_pkg::COORD_W'($urandom_range(row_top, 0));
    end else begin
      col = sckb_pkg::COORD_W'($urandom_range(511, 0));
      row = sckb_pkg::COORD_W'($urandom_range(511, 0));
    end
    pick = $urandom_range(99, 0);
    if ((blit_regs.ke && pick < 15) || pick < 4) pix = sckb_pkg::KEY_COLOR;
    else pix = sckb_pkg::PIX_W'($urandom_range(65535, 0));
    send_pixel(col, row, pix);
  endtask

  // random phases over register settings and sender idle rates
  task automatic test_random_traffic();
    int idle_rates[3];
    idle_rates = '{0, 66, 25};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      unique case (ph)
        0: load_blit_regs(make_cfg(479, 271, 480, 272, 8, 0, 1));
        1: load_blit_regs(make_cfg(0, 0, 1, 1, 1, 0, 0));
        2: load_blit_regs(make_cfg(511, 511, 511, 511, 15, 1, 1));
        3: load_blit_regs(make_cfg(0, 0, 480, 272, 1, 0, 0));
        default: load_blit_regs(rand_cfg());
      endcase
      sender_idle_pct = idle_rates[ph % 3];
      repeat (PHASE_PIXELS) send_rand_pixel();
      wait_idle();
    end
    sender_idle_pct = 0;
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d writes outstanding", cycle_count,
             pending_writes.size());
    $display("FAIL scaled_color_key_blitter");
    $finish;
  end

  initial begin
    blit_regs = make_cfg(0, 0, 1, 1, 1, 0, 0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_scaling();
    test_clipping();
    test_color_key();
    test_blocked_sources();
    test_random_traffic();
    wait_idle();
    $display("sent %0d pixels under %0d register settings, checked %0d writes",
             pixels_sent, settings_loaded, writes_seen);
    $display("scales 0 to 15, keying, both frames, edge clipping and line wrap, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS scaled_color_key_blitter");
    end else begin
      $display("FAIL scaled_color_key_blitter");
    end
    $finish;
  end

endmodule
